### hw/rtl/ilie_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list package
// Opcodes, status codes and the command that is broadcast to every list cell.
// ----------------------------------------------------------------------------
package ilie_pkg;

    // Default capacity of the list.
    localparam int LIST_DEPTH = 16;

    // Width of a cell index, wide enough for the largest supported capacity (64).
    localparam int IDX_W = 6;

    // Width of one stored word.
    localparam int WORD_W = 32;

    // Transaction opcodes.
    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_INSERT = 3'd2,
        OP_ERASE  = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_DUMP   = 3'd5
    } t_opcode;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // Operation that every cell carries out.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE,
        CELL_ROTATE
    } t_cell_op;

    // Command broadcast along the chain.
    typedef struct packed {
        t_cell_op           op;
        logic [IDX_W-1:0]   pos;   // insert or erase index
        logic [IDX_W-1:0]   tail;  // index of the last stored element
        logic [WORD_W-1:0]  word;  // word to insert
        logic [WORD_W-1:0]  wrap;  // head element fed back to the tail on rotation
    } t_cell_cmd;

endpackage

### hw/rtl/ilie_cell.sv
// ----------------------------------------------------------------------------
// Indexed list cell
// Holds one list element and takes a new value from its own command, its
// lower neighbour or its upper neighbour in the same cycle as all other cells.
// ----------------------------------------------------------------------------
module ilie_cell
    import ilie_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  logic              i_clk,
    input  t_cell_cmd         i_cmd,
    input  logic [WORD_W-1:0] i_lower,
    input  logic [WORD_W-1:0] i_upper,
    output logic [WORD_W-1:0] o_data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic [WORD_W-1:0] r_data;
    logic [WORD_W-1:0] n_data;

    // Select the next value of this element.
    always_comb begin
        n_data = r_data;
        unique case (i_cmd.op)
            CELL_INSERT: begin
                if (MY_IDX == i_cmd.pos) begin
                    n_data = i_cmd.word;
                end else if (MY_IDX > i_cmd.pos) begin
                    n_data = i_lower;
                end
            end
            CELL_ERASE: begin
                if (MY_IDX >= i_cmd.pos) begin
                    n_data = i_upper;
                end
            end
            CELL_ROTATE: begin
                if (MY_IDX == i_cmd.tail) begin
                    n_data = i_cmd.wrap;
                end else if (MY_IDX < i_cmd.tail) begin
                    n_data = i_upper;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    // Element storage; its contents are defined only once written.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

### hw/rtl/indexed_list_insert_erase.sv
// ----------------------------------------------------------------------------
// Indexed list with insert and erase
// Ordered list of signed 32-bit words held in a chain of cells.
// ----------------------------------------------------------------------------
// Push, pop, insert, erase and clear each give one result transaction, since
// every cell shifts towards its neighbour in parallel. An empty-list dump and
// an unused opcode also give a single result. A dump of a non-empty list
// starts the walk when it is accepted and then gives one result per stored
// element: the chain rotates by one place for each result, cell zero is read
// out, and after the last element the list is back in its original order.
// Each step waits while the output register is held by a stall. No new
// transaction is accepted while a dump is running. The output register lets a
// new transaction enter while the previous result is still being taken.
module indexed_list_insert_erase
    import ilie_pkg::*;
#(
    parameter int DEPTH = LIST_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_opcode,
    input  logic [4:0]         i_position,
    input  logic signed [31:0] i_word_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [4:0]         o_count,
    output logic signed [31:0] o_word_out,
    output logic               o_last
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [CW-1:0]      r_dump_idx;
    logic [CW-1:0]      n_dump_idx;
    logic               r_out_valid;
    logic               n_out_load;
    t_status            r_status;
    t_status            n_status;
    logic [WORD_W-1:0]  r_word;
    logic [WORD_W-1:0]  n_word;
    logic               r_last;
    logic               n_last;
    logic [4:0]         r_count_out;

    logic               w_slot;
    logic               w_acc;
    logic               w_dump_last;
    logic [CMPW-1:0]    w_pos_ext;
    logic [CMPW-1:0]    w_cnt_ext;
    logic [CW-1:0]      w_tail;
    t_cell_cmd          w_cmd;
    logic [WORD_W-1:0]  w_cell_data [DEPTH];

    // Handshake: the output register is free or is emptied this cycle.
    assign w_slot      = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state == S_DUMP) || !w_slot;
    assign w_acc       = i_in_valid && !o_in_stall;
    assign w_pos_ext   = CMPW'(i_position);
    assign w_cnt_ext   = CMPW'(r_count);
    assign w_tail      = r_count - 1'b1;
    assign w_dump_last = (r_dump_idx == w_tail);

    // Decode the transaction and build the chain command.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_dump_idx = r_dump_idx;
        n_out_load = 1'b0;
        n_status   = ST_OK;
        n_word     = '0;
        n_last     = 1'b1;
        w_cmd.op   = CELL_HOLD;
        w_cmd.pos  = IDX_W'(i_position);
        w_cmd.tail = IDX_W'(w_tail);
        w_cmd.word = i_word_in;
        w_cmd.wrap = w_cell_data[0];
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_out_load = 1'b1;
                    unique case (i_opcode)
                        OP_PUSH: begin
                            if (r_count >= FULL_COUNT) begin
                                n_status = ST_FULL;
                            end else begin
                                w_cmd.op  = CELL_INSERT;
                                w_cmd.pos = IDX_W'(r_count);
                                n_count   = r_count + 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        OP_INSERT: begin
                            if (w_pos_ext > w_cnt_ext) begin
                                n_status = ST_BAD_INDEX;
                            end else if (r_count >= FULL_COUNT) begin
                                n_status = ST_FULL;
                            end else begin
                                w_cmd.op = CELL_INSERT;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        OP_ERASE: begin
                            if (w_pos_ext >= w_cnt_ext) begin
                                n_status = ST_BAD_INDEX;
                            end else begin
                                w_cmd.op = CELL_ERASE;
                                n_count  = r_count - 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_DUMP: begin
                            // An empty list gives a single result at once.
                            if (r_count != '0) begin
                                n_out_load = 1'b0;
                                n_state    = S_DUMP;
                                n_dump_idx = '0;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                // Read out cell zero and rotate the stored part of the chain.
                if (w_slot) begin
                    w_cmd.op   = CELL_ROTATE;
                    n_out_load = 1'b1;
                    n_word     = w_cell_data[0];
                    n_last     = w_dump_last;
                    n_dump_idx = r_dump_idx + 1'b1;
                    if (w_dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Chain of element cells.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_W-1:0] w_lower;
        logic [WORD_W-1:0] w_upper;
        if (g == 0) begin : g_first
            assign w_lower = w_cell_data[g];
        end else begin : g_mid_lower
            assign w_lower = w_cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_end
            assign w_upper = w_cell_data[g];
        end else begin : g_mid_upper
            assign w_upper = w_cell_data[g+1];
        end
        ilie_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_data  (w_cell_data[g])
        );
    end

    // State, fill count and output register; the count field follows its result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dump_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_dump_idx <= n_dump_idx;
            if (n_out_load) begin
                r_out_valid <= 1'b1;
                r_status    <= n_status;
                r_word      <= n_word;
                r_last      <= n_last;
                r_count_out <= 5'(n_count);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_count     = r_count_out;
    assign o_word_out  = r_word;
    assign o_last      = r_last;

    // The fill count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("fill count above capacity");

    // A dump walks only over stored elements.
    a_dump_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (r_dump_idx < r_count))
        else $error("dump index beyond fill count");

    // The fill count does not move during a dump.
    a_dump_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |=> (r_count == $past(r_count)))
        else $error("fill count changed during dump");

    // The final dump element ends the dump and carries the last marker.
    a_dump_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP && w_slot && w_dump_last) |=>
            (r_state == S_IDLE && o_out_valid && o_last))
        else $error("dump did not end on its final element");

endmodule

### bench/indexed_list_insert_erase_tb.sv
// ----------------------------------------------------------------------------
// Indexed list insert/erase testbench
// Drives push, pop, insert, erase, clear, dump and the unused opcodes into the
// list, keeps a shadow copy of the list contents and checks every result
// transaction, field by field and in order, against the shadow's prediction.
// ----------------------------------------------------------------------------
module indexed_list_insert_erase_tb;
    import ilie_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Opcodes that the block must ignore.
    localparam logic [2:0] OP_UNUSED6 = 3'd6;
    localparam logic [2:0] OP_UNUSED7 = 3'd7;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 24;

    // One expected result transaction.
    typedef struct {
        t_status     status;
        logic [4:0]  count;
        logic [31:0] word;
        logic        last;
    } t_list_result;

    // Shadow of the list contents, with the queue of results still to come.
    class list_shadow;
        logic [31:0]  cells [LIST_DEPTH];
        int           fill;
        t_list_result expected_q [$];
        int           mismatches;
        int           results_checked;
        int           peak_fill;
        int           op_seen [8];
        int           status_seen [4];

        function new();
            fill            = 0;
            mismatches      = 0;
            results_checked = 0;
            peak_fill       = 0;
            foreach (op_seen[k]) op_seen[k] = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void add_expected(t_status st, logic [31:0] word, logic last);
            t_list_result r;
            r.status = st;
            r.count  = fill[4:0];
            r.word   = word;
            r.last   = last;
            expected_q = {expected_q, r};
            status_seen[st]++;
        endfunction

        // Apply one accepted command to the shadow and queue its results.
        function void accept_command(logic [2:0] op, logic [4:0] pos, logic [31:0] word);
            t_status st;
            int      p;
            int      k;
            st = ST_OK;
            p  = pos;
            op_seen[op]++;
            case (op)
                OP_PUSH: begin
                    if (fill >= LIST_DEPTH) begin
                        st = ST_FULL;
                    end else begin
                        cells[fill] = word;
                        fill++;
                    end
                end
                OP_POP: begin
                    if (fill == 0) st = ST_EMPTY;
                    else fill--;
                end
                OP_INSERT: begin
                    // The index check takes priority over the full check.
                    if (p > fill) begin
                        st = ST_BAD_INDEX;
                    end else if (fill >= LIST_DEPTH) begin
                        st = ST_FULL;
                    end else begin
                        for (k = fill; k > p; k--) cells[k] = cells[k-1];
                        cells[p] = word;
                        fill++;
                    end
                end
                OP_ERASE: begin
                    if (p >= fill) begin
                        st = ST_BAD_INDEX;
                    end else begin
                        for (k = p; k + 1 < fill; k++) cells[k] = cells[k+1];
                        fill--;
                    end
                end
                OP_CLEAR: begin
                    fill = 0;
                end
                OP_DUMP: begin
                    // A non-empty list gives one result per element.
                    if (fill != 0) begin
                        for (k = 0; k < fill; k++)
                            add_expected(ST_OK, cells[k], (k + 1 == fill));
                        return;
                    end
                end
                default: ;
            endcase
            if (fill > peak_fill) peak_fill = fill;
            add_expected(st, 32'd0, 1'b1);
        endfunction

        // Compare one result transaction with the oldest expectation.
        function void compare_result(logic [1:0] st, logic [4:0] cnt, logic [31:0] word,
                                     logic last);
            t_list_result e;
            results_checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %0d: status %0d count %0d word %h last %0d",
                             results_checked, st, cnt, word, last);
                return;
            end
            e = expected_q.pop_front();
            if (st !== e.status || cnt !== e.count || word !== e.word || last !== e.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch on result %0d:", results_checked);
                    $display("  expected status %0d count %0d word %h last %0d",
                             e.status, e.count, e.word, e.last);
                    $display("  actual   status %0d count %0d word %h last %0d",
                             st, cnt, word, last);
                end
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [2:0]         i_opcode;
    logic [4:0]         i_position;
    logic signed [31:0] i_word_in;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [1:0]         o_status;
    logic [4:0]         o_count;
    logic signed [31:0] o_word_out;
    logic               o_last;

    list_shadow shadow = new();

    bit tx_idle_en;
    bit rx_idle_en;
    bit hold_req;
    int cycles;
    int commands_sent;

    indexed_list_insert_erase #(
        .DEPTH (LIST_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_position  (i_position),
        .i_word_in   (i_word_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_count     (o_count),
        .o_word_out  (o_word_out),
        .o_last      (o_last)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, shadow.pending());
            $display("status: fail");
            $finish;
        end
    end

    // Every accepted result transaction is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            shadow.compare_result(o_status, o_count, o_word_out, o_last);
    end

    // Receiver: random stall bursts, or one long hold-off when asked for.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 10) - 1) @(negedge i_clk);
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    // Extreme words turn up often, the rest are fully random.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Offer one command and hold it until the block takes it.
    task automatic send_command(input logic [2:0] op, input logic [4:0] pos,
                                input logic [31:0] word);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_opcode   = op;
        i_position = pos;
        i_word_in  = word;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        shadow.accept_command(op, pos, word);
        commands_sent++;
    endtask

    // Sender gap, with noise on the payload.
    task automatic idle_sender(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            i_opcode   = 3'($urandom_range(0, 7));
            i_position = 5'($urandom_range(0, 31));
            i_word_in  = $urandom;
        end
    endtask

    task automatic wait_drained();
        while (shadow.pending() != 0) @(posedge i_clk);
    endtask

    // Random commands, mostly well formed against the current fill level.
    // Growth and shrink phases alternate so that the list reaches both ends.
    task automatic run_random(input int n);
        int          k;
        int          r;
        int          f;
        bit          grow;
        logic [2:0]  op;
        logic [4:0]  pos;
        for (k = 0; k < n; k++) begin
            if (tx_idle_en && $urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 10));
            grow = ((k / 40) % 2) == 0;
            f    = shadow.fill;
            r    = $urandom_range(0, 99);
            pos  = 5'($urandom_range(0, 31));
            if (r < (grow ? 35 : 12)) begin
                op = OP_PUSH;
            end else if (r < (grow ? 60 : 24)) begin
                op  = OP_INSERT;
                pos = 5'($urandom_range(0, f));
            end else if (r < (grow ? 70 : 54)) begin
                op  = OP_ERASE;
                pos = (f == 0) ? 5'd0 : 5'($urandom_range(0, f - 1));
            end else if (r < (grow ? 78 : 79)) begin
                op = OP_POP;
            end else if (r < 88) begin
                op = OP_DUMP;
            end else if (r < 94) begin
                // Index out of range.
                op  = $urandom_range(0, 1) ? OP_INSERT : OP_ERASE;
                pos = (op == OP_INSERT) ? 5'($urandom_range(f + 1, 31))
                                        : 5'($urandom_range(f, 31));
            end else if (r < (grow ? 96 : 97)) begin
                op = OP_CLEAR;
            end else begin
                op = $urandom_range(0, 1) ? OP_UNUSED6 : OP_UNUSED7;
            end
            send_command(op, pos, pick_word());
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_opcode      = OP_PUSH;
        i_position    = 5'd0;
        i_word_in     = 32'sd0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        hold_req      = 1'b0;
        cycles        = 0;
        commands_sent = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty list: dump, pop, erase and an insert past the end.
        send_command(OP_DUMP, 5'd0, 32'd0);
        send_command(OP_POP, 5'd0, 32'd0);
        send_command(OP_ERASE, 5'd0, 32'd0);
        send_command(OP_INSERT, 5'd1, 32'h1234_5678);

        // Edits at the head, the middle and the tail with the extreme words.
        send_command(OP_INSERT, 5'd0, 32'h8000_0000);
        send_command(OP_PUSH, 5'd31, 32'h7fff_ffff);
        send_command(OP_INSERT, 5'd1, 32'hffff_ffff);
        send_command(OP_INSERT, 5'd3, 32'h0000_0000);
        send_command(OP_ERASE, 5'd4, 32'd0);
        send_command(OP_ERASE, 5'd1, 32'd0);
        send_command(OP_UNUSED6, 5'd31, 32'haaaa_aaaa);
        send_command(OP_UNUSED7, 5'd16, 32'h5555_5555);
        send_command(OP_INSERT, 5'd31, 32'hdead_beef);
        send_command(OP_DUMP, 5'd0, 32'd0);

        // Fill to capacity, then the full-list cases and a full dump.
        while (shadow.fill < LIST_DEPTH)
            send_command(OP_PUSH, 5'($urandom_range(0, 31)), pick_word());
        send_command(OP_PUSH, 5'd0, 32'h0bad_0bad);
        send_command(OP_INSERT, 5'd16, 32'h0bad_0bad);
        send_command(OP_INSERT, 5'd17, 32'h0bad_0bad);
        send_command(OP_DUMP, 5'd0, 32'd0);
        send_command(OP_ERASE, 5'd15, 32'd0);
        send_command(OP_ERASE, 5'd0, 32'd0);
        send_command(OP_POP, 5'd0, 32'd0);
        send_command(OP_CLEAR, 5'd0, 32'd0);
        send_command(OP_DUMP, 5'd0, 32'd0);
        send_command(OP_POP, 5'd0, 32'd0);

        run_random(100);

        // Receiver holds off while commands keep coming, so the input backs up.
        hold_req = 1'b1;
        tx_idle_en = 1'b0;
        run_random(20);
        tx_idle_en = 1'b1;

        // Sender pauses until every outstanding result has arrived.
        idle_sender(1);
        wait_drained();

        run_random(100);

        // Closing stretch at full rate on both sides.
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_random(70);

        idle_sender(1);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d commands: push %0d, pop %0d, insert %0d, erase %0d, clear %0d,",
                 commands_sent, shadow.op_seen[OP_PUSH], shadow.op_seen[OP_POP],
                 shadow.op_seen[OP_INSERT], shadow.op_seen[OP_ERASE],
                 shadow.op_seen[OP_CLEAR]);
        $display("  dump %0d, unused %0d; %0d results checked (ok %0d, bad index %0d,",
                 shadow.op_seen[OP_DUMP],
                 shadow.op_seen[OP_UNUSED6] + shadow.op_seen[OP_UNUSED7],
                 shadow.results_checked, shadow.status_seen[ST_OK],
                 shadow.status_seen[ST_BAD_INDEX]);
        $display("  full %0d, empty %0d), peak fill %0d, %0d mismatches.",
                 shadow.status_seen[ST_FULL], shadow.status_seen[ST_EMPTY],
                 shadow.peak_fill, shadow.mismatches);
        if (shadow.mismatches == 0 && shadow.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/ilie_pkg.sv
hw/rtl/ilie_cell.sv
hw/rtl/indexed_list_insert_erase.sv
bench/indexed_list_insert_erase_tb.sv
